// ===== rtl/sfs_pkg.sv =====
// ----------------------------------------------------------------------------
// sfs_pkg: shared types and constants of the sprite frame sequencer
// Command and phase codes, register indexes, widths and the sequencer states.
// ----------------------------------------------------------------------------
package sfs_pkg;

  // Command codes carried in the input tuser field.
  localparam logic [2:0] FuncTick    = 3'd0;
  localparam logic [2:0] FuncPlay    = 3'd1;
  localparam logic [2:0] FuncPause   = 3'd2;
  localparam logic [2:0] FuncRestart = 3'd3;
  localparam logic [2:0] FuncSetFrm  = 3'd4;
  localparam logic [2:0] FuncWrTable = 3'd5;

  // Event phase codes.
  localparam logic [2:0] PhBegan  = 3'd0;
  localparam logic [2:0] PhNext   = 3'd1;
  localparam logic [2:0] PhLoop   = 3'd2;
  localparam logic [2:0] PhBounce = 3'd3;
  localparam logic [2:0] PhEnded  = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] RegFrameCount = 3'd0;
  localparam logic [2:0] RegFirstSheet = 3'd1;
  localparam logic [2:0] RegUseTable   = 3'd2;
  localparam logic [2:0] RegLoopLimit  = 3'd3;
  localparam logic [2:0] RegBounce     = 3'd4;
  localparam logic [2:0] RegSeqTime    = 3'd5;
  localparam logic [2:0] RegTimeScale  = 3'd6;
  localparam logic [2:0] RegSheetCount = 3'd7;

  localparam int unsigned TableDepth = 64;
  localparam int unsigned TableAw    = $clog2(TableDepth);
  localparam int unsigned SheetW     = 16;

  // Divider operand widths: the widest dividend is elapsed * scale * frames.
  localparam int unsigned DivNumW = 60;
  localparam int unsigned DivDenW = 27;
  localparam int unsigned DivCntW = $clog2(DivNumW + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_QSTART,
    S_QWAIT,
    S_WSTART,
    S_WWAIT,
    S_UPD,
    S_FSTART,
    S_FWAIT,
    S_FRD,
    S_FIN
  } state_e;

endpackage

// ===== rtl/sprite_frame_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// sprite_frame_sequencer_top: sprite animation frame sequencer
// Steps an animation on tick, play, pause, restart and set-frame requests and
// reports the sheet frame to show and the event phase.
// ----------------------------------------------------------------------------
//  channel  | direction | tdata (low bit up)                          | tuser
//  s_       | in        | now_ms, frame_position, table_sheet_frame   | func
//  m_       | out       | frame_valid, sheet_frame, event_valid,      | -
//           |           | phase, playing                              |
//  cfg_     | in        | register write, index cfg_idx_i             | -
//
// One request at a time. All division goes through one shared restoring
// divider of 60 steps: a timed tick runs the elapsed-time divide, the wrap
// modulo if endless and the frame modulo; a set frame with a pass time two
// divides; restart and tick-by-frame one; pause and table writes none.
// A finished result waits in the output register while the next request is
// taken. Table and work regs lack reset; rest is zero but counts 1, scale 256.
module sprite_frame_sequencer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // now_ms, frame_position, table_sheet_frame
  input  logic [2:0]  s_tuser,   // func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // frame_valid, sheet_frame, event_valid, phase, playing
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);
  import sfs_pkg::*;

  // Configuration.
  logic [10:0] fc_q;
  logic [15:0] first_q, seq_q, scale_q, sfc_q;
  logic [7:0]  lim_q;
  logic        usetab_q, bounce_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fc_q     <= 11'd1;
      first_q  <= '0;
      usetab_q <= 1'b0;
      lim_q    <= '0;
      bounce_q <= 1'b0;
      seq_q    <= '0;
      scale_q  <= 16'd256;
      sfc_q    <= 16'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegFrameCount: fc_q     <= cfg_data_i[10:0];
        RegFirstSheet: first_q  <= cfg_data_i;
        RegUseTable:   usetab_q <= cfg_data_i[0];
        RegLoopLimit:  lim_q    <= cfg_data_i[7:0];
        RegBounce:     bounce_q <= cfg_data_i[0];
        RegSeqTime:    seq_q    <= cfg_data_i;
        RegTimeScale:  scale_q  <= cfg_data_i;
        RegSheetCount: sfc_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Derived configuration values.
  logic [10:0] n, nm1;
  logic [11:0] md2;
  logic [15:0] scale_e;
  logic [18:0] li_n, li_nm1;
  logic [20:0] ne, ne_m1;
  logic        inf;

  assign n       = (fc_q == '0) ? 11'd1 : fc_q;
  assign nm1     = n - 11'd1;
  assign md2     = {nm1, 1'b0};
  assign scale_e = (scale_q == '0) ? 16'd1 : scale_q;
  assign inf     = (lim_q == '0);
  assign li_n    = 19'(lim_q) * 19'(n);
  assign li_nm1  = 19'(lim_q) * 19'(nm1);
  assign ne_m1   = ne - 21'd1;

  always_comb begin
    if (!bounce_q) begin
      ne = inf ? 21'(n) : 21'(li_n);
    end else if (!inf) begin
      ne = (n > 11'd1) ? (21'({li_nm1, 1'b0}) + 21'd1) : 21'(lim_q);
    end else begin
      ne = (n == 11'd1) ? 21'd1 : 21'(md2);
    end
  end

  // Sequencer state.
  state_e      state_q, state_d;
  logic [19:0] pos_q, pos_d;
  logic [31:0] start_q, start_d, paused_q, paused_d;
  logic        play_q, play_d, began_q, began_d, ended_q, ended_d;
  logic        m_valid_q, m_valid_d;

  // Per-request working registers.
  logic [2:0]         func_q, func_d;
  logic [31:0]        now_q, now_d;
  logic [19:0]        i_q, i_d;
  logic [26:0]        prod_q, prod_d;
  logic [DivNumW-1:0] num_q, num_d;
  logic [DivDenW-1:0] den_q, den_d;
  logic               wrapd_q, wrapd_d, fvalid_q, fvalid_d, disp_q, disp_d;
  logic [2:0]         ph_q, ph_d, p_q, p_d;
  logic [10:0]        refl_q, refl_d;
  logic [23:0]        m_data_q, m_data_d;

  // Input fields.
  logic        s_acc;
  logic [2:0]  in_func;
  logic [31:0] in_now;
  logic [10:0] in_fpos;
  logic [15:0] in_tval;

  assign in_func = s_tuser;
  assign in_now  = s_tdata[31:0];
  assign in_fpos = s_tdata[42:32];
  assign in_tval = s_tdata[58:43];
  assign s_tready = (state_q == S_IDLE);
  assign s_acc    = s_tvalid && s_tready;

  logic playing_now, tick_go;
  assign playing_now = play_q && (21'(pos_q) < ne);
  assign tick_go     = playing_now && (in_now >= start_q);

  // Shared divider.
  logic               div_start, div_done;
  logic [DivNumW-1:0] div_num, div_quot;
  logic [DivDenW-1:0] div_den, div_rem;

  sfs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot),
    .rem_o   (div_rem)
  );

  // Frame table.
  logic [15:0] tab_rdata;
  logic        tab_we;

  assign tab_we = s_acc && (in_func == FuncWrTable) && (32'(in_fpos) < TableDepth);

  sfs_ram #(
    .Width (16),
    .Depth (TableDepth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tab_we),
    .waddr_i (in_fpos[TableAw-1:0]),
    .wdata_i (in_tval),
    .raddr_i (refl_q[TableAw-1:0]),
    .rdata_o (tab_rdata)
  );

  // Common helper values.
  logic [10:0]        set_idx;
  logic [19:0]        step_pos;
  logic [20:0]        idxc;
  logic               fbypass;
  logic [DivNumW-1:0] idxv;
  logic [11:0]        jm;
  logic [58:0]        mulp;
  logic [31:0]        dt;

  assign set_idx  = (in_fpos > n) ? n : in_fpos;
  assign step_pos = pos_q + 20'd1;
  assign idxc     = (21'(i_q) > ne_m1) ? ne_m1 : 21'(i_q);
  assign fbypass  = bounce_q && (n == 11'd1);
  assign idxv     = inf ? DivNumW'(div_rem) : div_quot;
  assign jm       = (state_q == S_FWAIT) ? div_rem[11:0] : 12'd0;
  assign dt       = now_q - start_q;
  assign mulp     = 59'(dt) * 59'(prod_q);

  // Divider operand selection.
  always_comb begin
    div_start = 1'b0;
    div_num   = num_q;
    div_den   = den_q;
    unique case (state_q)
      S_QSTART: div_start = 1'b1;
      S_WSTART: begin
        div_start = 1'b1;
        div_num   = div_quot;
        div_den   = DivDenW'(ne);
      end
      S_FSTART: begin
        div_start = !fbypass;
        div_num   = DivNumW'(idxc);
        div_den   = bounce_q ? DivDenW'(md2) : DivDenW'(n);
      end
      default: ;
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_acc) begin
          priority case (in_func)
            FuncTick: begin
              if (!tick_go) state_d = S_FIN;
              else if (!began_q) state_d = S_FSTART;
              else if (seq_q != '0) state_d = S_MUL1;
              else state_d = S_FSTART;
            end
            FuncPlay:    state_d = ended_q ? S_FSTART : S_FIN;
            FuncRestart: state_d = S_FSTART;
            FuncSetFrm:  state_d = (seq_q != '0) ? S_MUL1 : S_FSTART;
            default:     state_d = S_FIN;
          endcase
        end
      end
      S_MUL1:   state_d = S_MUL2;
      S_MUL2:   state_d = S_QSTART;
      S_QSTART: state_d = S_QWAIT;
      S_QWAIT: begin
        if (div_done) begin
          if (func_q == FuncSetFrm) state_d = S_FSTART;
          else if (inf) state_d = S_WSTART;
          else state_d = S_UPD;
        end
      end
      S_WSTART: state_d = S_WWAIT;
      S_WWAIT:  if (div_done) state_d = S_UPD;
      S_UPD:    state_d = fvalid_d ? S_FSTART : S_FIN;
      S_FSTART: state_d = fbypass ? S_FRD : S_FWAIT;
      S_FWAIT:  if (div_done) state_d = S_FRD;
      S_FRD:    state_d = S_FIN;
      S_FIN:    if (!m_valid_q || m_tready) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Datapath and result.
  logic [16:0] seqv;
  logic [15:0] mx, sheet;
  logic [2:0]  ph_out;
  logic        playing_out;

  always_comb begin
    if (usetab_q) begin
      seqv = (32'(refl_q) < TableDepth) ? 17'(tab_rdata) : 17'd0;
    end else begin
      seqv = 17'(first_q) + 17'(refl_q);
    end
    mx    = (sfc_q == '0) ? 16'd0 : sfc_q - 16'd1;
    sheet = !fvalid_q ? 16'd0 : ((seqv > 17'(mx)) ? mx : seqv[15:0]);
    ph_out = ph_q;
    if (disp_q && p_q != PhNext && ph_q == PhNext) begin
      ph_out = p_q;
    end
    if (!disp_q) begin
      ph_out = 3'd0;
    end
    playing_out = play_q && (21'(pos_q) < ne);
  end

  always_comb begin
    pos_d     = pos_q;
    start_d   = start_q;
    paused_d  = paused_q;
    play_d    = play_q;
    began_d   = began_q;
    ended_d   = ended_q;
    m_valid_d = m_valid_q && !m_tready;
    func_d    = func_q;
    now_d     = now_q;
    i_d       = i_q;
    prod_d    = prod_q;
    num_d     = num_q;
    den_d     = den_q;
    wrapd_d   = wrapd_q;
    fvalid_d  = fvalid_q;
    disp_d    = disp_q;
    ph_d      = ph_q;
    p_d       = p_q;
    refl_d    = refl_q;
    m_data_d  = m_data_q;

    unique case (state_q)
      S_IDLE: begin
        if (s_acc) begin
          func_d   = in_func;
          now_d    = in_now;
          fvalid_d = 1'b0;
          disp_d   = 1'b0;
          ph_d     = PhNext;
          i_d      = '0;
          priority case (in_func)
            FuncTick: begin
              if (tick_go) begin
                if (!began_q) begin
                  i_d      = pos_q;
                  began_d  = 1'b1;
                  disp_d   = 1'b1;
                  fvalid_d = 1'b1;
                  ph_d     = PhBegan;
                end else if (seq_q == '0) begin
                  disp_d   = 1'b1;
                  fvalid_d = 1'b1;
                  i_d      = step_pos;
                  pos_d    = step_pos;
                  if (inf) begin
                    if (21'(step_pos) >= ne) begin
                      i_d   = '0;
                      pos_d = '0;
                      ph_d  = PhLoop;
                    end
                  end else if (21'(step_pos) >= ne_m1) begin
                    i_d   = ne_m1[19:0];
                    pos_d = ne_m1[19:0];
                    if (!ended_q) begin
                      play_d  = 1'b0;
                      ended_d = 1'b1;
                      ph_d    = PhEnded;
                    end
                  end
                end
              end
            end
            FuncPlay: begin
              // Play after the end rewinds to the first frame and starts playing again.
              if (ended_q) begin
                fvalid_d = 1'b1;
                pos_d    = '0;
                play_d   = 1'b1;
                began_d  = 1'b0;
                ended_d  = 1'b0;
                paused_d = '0;
                start_d  = in_now;
              end else if (!playing_now) begin
                if (paused_q != '0) begin
                  start_d  = in_now - paused_q;
                  paused_d = '0;
                end
                if (!play_q) begin
                  play_d = 1'b1;
                  if (((paused_q != '0) ? (in_now - paused_q) : start_q) == '0) begin
                    start_d = in_now;
                  end
                end
              end
            end
            FuncPause: begin
              if (playing_now) begin
                paused_d = in_now - start_q;
                start_d  = '0;
                play_d   = 1'b0;
              end
            end
            FuncRestart: begin
              fvalid_d = 1'b1;
              pos_d    = '0;
              start_d  = '0;
              paused_d = '0;
              play_d   = 1'b0;
              began_d  = 1'b0;
              ended_d  = 1'b0;
            end
            FuncSetFrm: begin
              fvalid_d = 1'b1;
              pos_d    = 20'(set_idx);
              i_d      = 20'(set_idx);
            end
            default: ;
          endcase
        end
      end
      S_MUL1: begin
        prod_d = (func_q == FuncSetFrm) ? 27'(seq_q) * 27'(i_q[10:0])
                                        : 27'(scale_e) * 27'(n);
      end
      S_MUL2: begin
        if (func_q == FuncSetFrm) begin
          num_d = DivNumW'({prod_q, 8'd0});
          den_d = 27'(scale_e) * 27'(n);
        end else begin
          num_d = DivNumW'(mulp);
          den_d = DivDenW'({seq_q, 8'd0});
        end
      end
      S_QWAIT: begin
        if (div_done && func_q == FuncSetFrm) begin
          start_d = now_q - div_quot[31:0];
        end
      end
      S_WSTART: wrapd_d = (div_quot >= DivNumW'(ne));
      S_UPD: begin
        if (inf && wrapd_q && idxv < DivNumW'(pos_q)) begin
          disp_d   = 1'b1;
          ph_d     = PhLoop;
          pos_d    = '0;
          i_d      = '0;
          fvalid_d = 1'b1;
        end
        if (idxv > DivNumW'(pos_d)) begin
          disp_d   = 1'b1;
          ph_d     = PhNext;
          fvalid_d = 1'b1;
          if (!inf && idxv >= DivNumW'(ne_m1)) begin
            pos_d = ne_m1[19:0];
            if (!ended_q) begin
              play_d  = 1'b0;
              ended_d = 1'b1;
              ph_d    = PhEnded;
            end
          end else begin
            pos_d = idxv[19:0];
          end
          i_d = pos_d;
        end
      end
      S_FSTART, S_FWAIT: begin
        if (state_q == S_FSTART ? fbypass : div_done) begin
          p_d = PhNext;
          if (!bounce_q) begin
            refl_d = jm[10:0];
            if (jm == '0) p_d = PhLoop;
          end else if (jm < 12'(n)) begin
            refl_d = jm[10:0];
            if (jm == 12'(nm1)) p_d = PhBounce;
            else if (jm == '0) p_d = PhLoop;
          end else begin
            refl_d = 11'(md2 - jm);
          end
        end
      end
      S_FIN: begin
        if (!m_valid_q || m_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = {2'b00, playing_out, ph_out, disp_q, sheet, fvalid_q};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      pos_q     <= '0;
      start_q   <= '0;
      paused_q  <= '0;
      play_q    <= 1'b0;
      began_q   <= 1'b0;
      ended_q   <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      pos_q     <= pos_d;
      start_q   <= start_d;
      paused_q  <= paused_d;
      play_q    <= play_d;
      began_q   <= began_d;
      ended_q   <= ended_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q   <= func_d;
    now_q    <= now_d;
    i_q      <= i_d;
    prod_q   <= prod_d;
    num_q    <= num_d;
    den_q    <= den_d;
    wrapd_q  <= wrapd_d;
    fvalid_q <= fvalid_d;
    disp_q   <= disp_d;
    ph_q     <= ph_d;
    p_q      <= p_d;
    refl_q   <= refl_d;
    m_data_q <= m_data_d;
  end

  assign m_tvalid = m_valid_q;
  assign m_tdata  = m_data_q;

endmodule

// ===== rtl/sfs_ram.sv =====
// ----------------------------------------------------------------------------
// sfs_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module sfs_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/sfs_div.sv =====
// ----------------------------------------------------------------------------
// sfs_div: restoring divider, one quotient bit per cycle
// Gives quotient and remainder of an unsigned division once all DivNumW steps are through.
// ----------------------------------------------------------------------------
module sfs_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [sfs_pkg::DivNumW-1:0] num_i,
  input  logic [sfs_pkg::DivDenW-1:0] den_i,
  output logic                        done_o,
  output logic [sfs_pkg::DivNumW-1:0] quot_o,
  output logic [sfs_pkg::DivDenW-1:0] rem_o
);
  import sfs_pkg::*;

  logic               busy_q, done_q;
  logic [DivCntW-1:0] cnt_q;
  logic [DivNumW-1:0] quot_q;
  logic [DivDenW-1:0] rem_q, den_q;
  logic [DivDenW:0]   trial;
  logic               fits;

  // Shift in the next dividend bit and try to subtract the divisor.
  assign trial = {rem_q, quot_q[DivNumW-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= DivCntW'(DivNumW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == DivCntW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= num_i;
      rem_q  <= '0;
      den_q  <= den_i;
    end else if (busy_q) begin
      quot_q <= {quot_q[DivNumW-2:0], fits};
      rem_q  <= fits ? DivDenW'(trial - {1'b0, den_q}) : trial[DivDenW-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

// ===== verif/sprite_frame_sequencer_top_tb.sv =====
// ----------------------------------------------------------------------------
// sprite_frame_sequencer_top_tb: self-checking bench of the sprite sequencer
// Drives tick, play, pause, restart, set-frame and table-write requests under
// a range of register settings and idle patterns. A behavioral copy of the
// sequencer predicts every response, which is compared field by field.
// ----------------------------------------------------------------------------
module sprite_frame_sequencer_top_tb;
  import sfs_pkg::*;

  localparam logic [2:0] FuncSpare6 = 3'd6;
  localparam logic [2:0] FuncSpare7 = 3'd7;
  localparam longint unsigned TimeMask = 64'hFFFF_FFFF;
  localparam int unsigned IdleLimit = 20000;

  // Packed from the top bit down, so frame_valid lands in bit 0.
  typedef struct packed {
    logic        playing;
    logic [2:0]  phase;
    logic        event_valid;
    logic [15:0] sheet_frame;
    logic        frame_valid;
  } frame_resp_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;   // now_ms, frame_position, table_sheet_frame
  logic [2:0]  s_tuser;   // func
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;   // frame_valid, sheet_frame, event_valid, phase, playing
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;

  sprite_frame_sequencer_top dut (.*);

  // Register copies.
  int unsigned frame_count, first_sheet, use_table, loop_limit, bounce;
  int unsigned seq_time, time_scale, sheet_count;
  // Sequencer state copy.
  int unsigned     seq_pos;
  longint unsigned start_ms, paused_ms;
  bit              fl_play, fl_began, fl_ended;
  logic [15:0]     frame_table [TableDepth];
  bit              table_filled;

  frame_resp_t expected_frames[$];
  int unsigned send_idle_pct, recv_stall_pct;
  int unsigned mismatches, responses, requests;
  int unsigned idle_cycles;
  longint unsigned clock_ms;

  function automatic int unsigned raw_frames();
    return (frame_count != 0) ? frame_count : 1;
  endfunction

  function automatic int unsigned total_frames();
    int unsigned n;
    n = raw_frames();
    if (bounce == 0) return (loop_limit != 0) ? loop_limit * n : n;
    if (loop_limit != 0) return (n > 1) ? 2 * loop_limit * (n - 1) + 1 : loop_limit;
    return (n == 1) ? 1 : 2 * (n - 1);
  endfunction

  function automatic int unsigned clamp_sheet(int unsigned idx);
    int unsigned v, mx;
    if (use_table != 0) v = (idx < TableDepth) ? frame_table[idx] : 0;
    else v = first_sheet + idx;
    mx = (sheet_count != 0) ? sheet_count - 1 : 0;
    return (v > mx) ? mx : v;
  endfunction

  // Maps a sequence position to a sheet frame; flags loop and bounce points.
  function automatic int unsigned map_frame(longint unsigned index, inout int ph);
    int unsigned ne, n, idx;
    ne = total_frames();
    n = raw_frames();
    idx = (index > longint'(ne - 1)) ? ne - 1 : int'(index);
    if (bounce == 0) begin
      if (idx >= n) idx = idx % n;
      if (idx == 0) ph = PhLoop;
      return clamp_sheet(idx);
    end
    if (loop_limit != 0) idx = (n > 1) ? idx % (2 * (n - 1)) : 0;
    else idx = (n == 1) ? 0 : idx % ne;
    if (idx < n) begin
      if (idx == n - 1) ph = PhBounce;
      else if (idx == 0) ph = PhLoop;
      return clamp_sheet(idx);
    end
    return clamp_sheet(2 * (n - 1) - idx);
  endfunction

  function automatic bit is_playing();
    return fl_play && (seq_pos < total_frames());
  endfunction

  function automatic int unsigned rewind();
    int p;
    p = PhNext;
    {fl_play, fl_began, fl_ended} = '0;
    seq_pos = 0;
    start_ms = 0;
    paused_ms = 0;
    return map_frame(0, p);
  endfunction

  function automatic frame_resp_t predict_frame(logic [2:0] func, longint unsigned now,
                                                int unsigned fpos, logic [15:0] tval);
    frame_resp_t r;
    int unsigned ne, n, cl;
    int ph, p;
    bit disp, adv, inf, done;
    longint unsigned i, idx, dt, pt;
    r = '0;
    case (func)
      FuncTick: begin
        if (is_playing() && now >= start_ms) begin
          ne = total_frames();
          ph = 11; disp = 0; adv = 0; i = 0;
          if (!fl_began) begin
            i = seq_pos; adv = 1; fl_began = 1; disp = 1; ph = PhBegan;
          end else if (seq_time > 0) begin
            dt = (now - start_ms) & TimeMask;
            idx = dt * ((time_scale != 0) ? time_scale : 1) * raw_frames()
                  / (256 * longint'(seq_time));
            inf = (loop_limit == 0);
            if (inf) begin
              done = idx >= ne;
              idx = idx % ne;
              if (done && idx < seq_pos) begin
                disp = 1; ph = PhLoop; seq_pos = 0; i = 0; adv = 1;
              end
            end
            if (idx > seq_pos) begin
              disp = 1; ph = PhNext;
              if (!inf && idx >= ne - 1) begin
                idx = ne - 1;
                if (!fl_ended) begin
                  fl_play = 0; fl_ended = 1; ph = PhEnded;
                end
              end
              seq_pos = int'(idx); i = idx; adv = 1;
            end
          end else begin
            seq_pos = (seq_pos + 1) & 20'hFFFFF;
            i = seq_pos; adv = 1; disp = 1; ph = PhNext;
            if (loop_limit == 0) begin
              if (i >= ne) begin
                i = 0; seq_pos = 0; ph = PhLoop;
              end
            end else if (i >= ne - 1) begin
              i = ne - 1; seq_pos = int'(i);
              if (!fl_ended) begin
                fl_play = 0; fl_ended = 1; ph = PhEnded;
              end
            end
          end
          if (adv && i < ne) begin
            p = PhNext;
            r.sheet_frame = 16'(map_frame(i, p));
            r.frame_valid = 1;
            if (disp && p != PhNext && ph == PhNext) ph = p;
          end
          if (disp) begin
            r.event_valid = 1;
            r.phase = ph[2:0];
          end
        end
      end
      FuncPlay: begin
        if (fl_ended) begin
          r.sheet_frame = 16'(rewind());
          r.frame_valid = 1;
        end
        if (!is_playing()) begin
          if (paused_ms > 0) begin
            start_ms = (now - paused_ms) & TimeMask;
            paused_ms = 0;
          end
          if (!fl_play) begin
            fl_play = 1;
            if (start_ms == 0) start_ms = now;
          end
        end
      end
      FuncPause: begin
        if (is_playing()) begin
          paused_ms = (now - start_ms) & TimeMask;
          start_ms = 0;
          fl_play = 0;
        end
      end
      FuncRestart: begin
        r.sheet_frame = 16'(rewind());
        r.frame_valid = 1;
      end
      FuncSetFrm: begin
        n = raw_frames();
        cl = (fpos > n) ? n : fpos;
        if (seq_time > 0) begin
          pt = longint'(seq_time) * cl * 256
               / (longint'(n) * ((time_scale != 0) ? time_scale : 1));
          start_ms = (now - pt) & TimeMask;
        end
        seq_pos = cl;
        p = PhNext;
        r.sheet_frame = 16'(map_frame(cl, p));
        r.frame_valid = 1;
      end
      FuncWrTable: begin
        if (fpos < TableDepth) frame_table[fpos] = tval;
      end
      default: ;
    endcase
    r.playing = is_playing();
    return r;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Response side: random stall, then check on each accepted response.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    frame_resp_t got, exp_r;
    if (rst_ni && ((s_tvalid && s_tready) || (m_tvalid && m_tready))) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("%0t: no handshake for %0d cycles", $time, IdleLimit);
      $display("simulation failed");
      $finish;
    end
    if (rst_ni && m_tvalid && m_tready) begin
      got = m_tdata[21:0];
      responses++;
      if (expected_frames.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected response %h", $time, got);
      end else begin
        exp_r = expected_frames.pop_front();
        if (got.frame_valid !== exp_r.frame_valid || got.sheet_frame !== exp_r.sheet_frame ||
            got.event_valid !== exp_r.event_valid || got.phase !== exp_r.phase ||
            got.playing !== exp_r.playing) begin
          mismatches++;
          $display("%0t: mismatch expected fv=%0d sf=%0d ev=%0d ph=%0d pl=%0d",
                   $time, exp_r.frame_valid, exp_r.sheet_frame, exp_r.event_valid,
                   exp_r.phase, exp_r.playing);
          $display("%0t:          actual   fv=%0d sf=%0d ev=%0d ph=%0d pl=%0d",
                   $time, got.frame_valid, got.sheet_frame, got.event_valid,
                   got.phase, got.playing);
        end
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(logic [2:0] func, logic [31:0] now, logic [10:0] fpos,
                              logic [15:0] tval);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= {5'b0, tval, fpos, now};
    expected_frames.push_back(predict_frame(func, now, fpos, tval));
    requests++;
    do @(posedge clk_i); while (!s_tready);
    @(negedge clk_i);
  endtask

  task automatic write_registers(int unsigned fc, int unsigned fs, int unsigned ut,
                                 int unsigned ll, int unsigned bm, int unsigned st,
                                 int unsigned ts, int unsigned sc);
    logic [15:0] vals [8];
    vals = '{16'(fc), 16'(fs), 16'(ut), 16'(ll), 16'(bm), 16'(st), 16'(ts), 16'(sc)};
    s_tvalid <= 1'b0;
    while (expected_frames.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    for (int k = 0; k < 8; k++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= k[2:0];
      cfg_data_i <= vals[k];
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
    frame_count = fc; first_sheet = fs; use_table = ut; loop_limit = ll;
    bounce = bm; seq_time = st; time_scale = ts; sheet_count = sc;
    @(negedge clk_i);
  endtask

  task automatic test_directed();
    write_registers(3, 65534, 0, 1, 0, 0, 256, 65535);
    send_request(FuncTick, 32'd10, 11'd0, 16'd0);        // tick before play
    send_request(FuncPlay, 32'd100, 11'd0, 16'd0);
    send_request(FuncTick, 32'd50, 11'd0, 16'd0);        // time below start
    send_request(FuncTick, 32'd110, 11'd0, 16'd0);
    send_request(FuncTick, 32'd120, 11'd0, 16'd0);
    send_request(FuncTick, 32'd130, 11'd0, 16'd0);
    send_request(FuncTick, 32'd140, 11'd0, 16'd0);       // after end
    send_request(FuncPlay, 32'd150, 11'd0, 16'd0);       // play after end
    send_request(FuncPause, 32'd160, 11'd0, 16'd0);
    send_request(FuncPlay, 32'hFFFF_FFFF, 11'd0, 16'd0);
    send_request(FuncSetFrm, 32'd0, 11'd1024, 16'd0);    // beyond frame count
    send_request(FuncSetFrm, 32'd5, 11'd0, 16'd0);
    send_request(FuncWrTable, 32'd0, 11'd63, 16'hFFFF);
    send_request(FuncWrTable, 32'd0, 11'd64, 16'h1234);  // beyond table depth
    send_request(FuncWrTable, 32'd0, 11'd1024, 16'h5A5A);
    send_request(FuncSpare6, 32'd7, 11'd3, 16'd1);
    send_request(FuncSpare7, 32'hFFFF_FFFF, 11'h7FF, 16'hFFFF);
    send_request(FuncRestart, 32'd200, 11'd0, 16'd0);
    write_registers(1024, 0, 0, 0, 1, 65535, 65535, 1);
    send_request(FuncPlay, 32'd0, 11'd0, 16'd0);
    send_request(FuncTick, 32'd1, 11'd0, 16'd0);
    send_request(FuncTick, 32'hFFFF_FFFF, 11'd0, 16'd0);
    send_request(FuncSetFrm, 32'd3, 11'd1023, 16'd0);
  endtask

  task automatic test_table_fill();
    for (int k = 0; k < TableDepth; k++)
      send_request(FuncWrTable, $urandom, k[10:0], 16'($urandom_range(0, 65535)));
    table_filled = 1;
  endtask

  task automatic random_request();
    int unsigned pick;
    logic [2:0] func;
    logic [10:0] fpos;
    pick = $urandom_range(99);
    if (pick < 50) func = FuncTick;
    else if (pick < 60) func = FuncPlay;
    else if (pick < 67) func = FuncPause;
    else if (pick < 72) func = FuncRestart;
    else if (pick < 84) func = FuncSetFrm;
    else if (pick < 96) func = FuncWrTable;
    else func = pick[0] ? FuncSpare6 : FuncSpare7;
    if ($urandom_range(19) == 0) clock_ms = $urandom;
    else clock_ms = (clock_ms + $urandom_range(0, 80)) & TimeMask;
    fpos = ($urandom_range(9) == 0) ? 11'($urandom_range(0, 1024))
                                    : 11'($urandom_range(0, 70));
    send_request(func, clock_ms[31:0], fpos, 16'($urandom_range(0, 65535)));
  endtask

  task automatic test_random_settings(int unsigned per_setting);
    int unsigned fc, ll, st, ts, sc;
    for (int s = 0; s < 3; s++) begin
      case ($urandom_range(4))
        0: fc = 1;
        1: fc = 1024;
        default: fc = $urandom_range(2, 12);
      endcase
      case ($urandom_range(3))
        0: ll = 0;
        1: ll = 255;
        default: ll = $urandom_range(1, 4);
      endcase
      case ($urandom_range(4))
        0, 1: st = 0;
        2: st = 65535;
        default: st = $urandom_range(20, 600);
      endcase
      case ($urandom_range(3))
        0: ts = 1;
        1: ts = 65535;
        default: ts = $urandom_range(64, 1024);
      endcase
      sc = ($urandom_range(3) == 0) ? $urandom_range(1, 65535) :
           (($urandom_range(1) != 0) ? 65535 : $urandom_range(1, 8));
      write_registers(fc, $urandom_range(0, 65535), table_filled & $urandom_range(1),
                      ll, $urandom_range(1), st, ts, sc);
      send_request(FuncRestart, clock_ms[31:0], 11'd0, 16'd0);
      for (int k = 0; k < per_setting; k++) random_request();
    end
  endtask

  initial begin
    int unsigned idle_table [4][2];
    idle_table = '{'{0, 0}, '{65, 0}, '{0, 65}, '{18, 18}};
    rst_ni = 1'b0;
    s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0;
    cfg_we_i = 1'b0; cfg_idx_i = '0; cfg_data_i = '0;
    frame_count = 1; first_sheet = 0; use_table = 0; loop_limit = 0; bounce = 0;
    seq_time = 0; time_scale = 256; sheet_count = 1;
    seq_pos = 0; start_ms = 0; paused_ms = 0;
    {fl_play, fl_began, fl_ended} = '0;
    table_filled = 0; clock_ms = 1000;
    send_idle_pct = 0; recv_stall_pct = 0;
    mismatches = 0; responses = 0; requests = 0; idle_cycles = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_table_fill();
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_table[ph][0];
      recv_stall_pct = idle_table[ph][1];
      test_random_settings(70);
    end
    s_tvalid <= 1'b0;
    while (expected_frames.size() != 0) @(negedge clk_i);
    repeat (250) @(negedge clk_i);
    $display("Sent %0d requests and checked %0d responses over 12 random settings,",
             requests, responses);
    $display("covering timed and per-tick advance, bounce, loops and the frame table.");
    if (mismatches == 0 && expected_frames.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
